>>> design/rtcca_pkg.sv
// ----------------------------------------------------------------------------
// rtcca_pkg: shared types and constants of the rtc calendar/alarm block
// register map, control bit positions, request kinds and time record types
// ----------------------------------------------------------------------------
`default_nettype none

package rtcca_pkg;

  // default size of the battery-backed user ram
  localparam int unsigned RAM_BYTES_DEFAULT = 50;

  // request kinds carried in req_type
  typedef enum logic [1:0] {
    REQ_READ       = 2'd0,
    REQ_WRITE      = 2'd1,
    REQ_TICK       = 2'd2,
    REQ_SOFT_RESET = 2'd3
  } req_kind_t;

  // register map
  localparam logic [5:0] ADDR_SEC        = 6'h00;
  localparam logic [5:0] ADDR_ALARM_SEC  = 6'h01;
  localparam logic [5:0] ADDR_MIN        = 6'h02;
  localparam logic [5:0] ADDR_ALARM_MIN  = 6'h03;
  localparam logic [5:0] ADDR_HOUR       = 6'h04;
  localparam logic [5:0] ADDR_ALARM_HOUR = 6'h05;
  localparam logic [5:0] ADDR_WEEKDAY    = 6'h06;
  localparam logic [5:0] ADDR_DAY        = 6'h07;
  localparam logic [5:0] ADDR_MONTH      = 6'h08;
  localparam logic [5:0] ADDR_YEAR       = 6'h09;
  localparam logic [5:0] ADDR_CTRL_A     = 6'h0A;
  localparam logic [5:0] ADDR_CTRL_B     = 6'h0B;
  localparam logic [5:0] ADDR_FLAGS      = 6'h0C;
  localparam logic [5:0] ADDR_STATUS     = 6'h0D;
  localparam logic [5:0] RAM_BASE        = 6'h0E;

  // ctrl_b bit positions
  localparam int unsigned CTRL_B_DSE  = 0;
  localparam int unsigned CTRL_B_24H  = 1;
  localparam int unsigned CTRL_B_BIN  = 2;
  localparam int unsigned CTRL_B_UIE  = 4;
  localparam int unsigned CTRL_B_AIE  = 5;
  localparam int unsigned CTRL_B_SET  = 7;

  localparam logic [7:0] CTRL_B_RESET     = 8'h06;
  localparam logic [7:0] CTRL_B_SOFT_MASK = 8'h87;
  localparam logic [7:0] STATUS_D_VALUE   = 8'h80;

  // time of day and calendar, raw register bytes
  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] weekday;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } time_t;

  localparam time_t TIME_RESET = '{
    sec: 8'h00, min: 8'h00, hour: 8'h00, weekday: 8'h01,
    day: 8'h01, month: 8'h01, year: 8'h00
  };

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
  } alarm_t;

  // flag register, only the bits that can ever be set
  typedef struct packed {
    logic irqf;
    logic af;
    logic uf;
  } flags_t;

  // outcome of one second advance
  typedef struct packed {
    time_t nxt;
    logic  fb_set;
    logic  alarm_match;
  } tick_t;

endpackage

`default_nettype wire

>>> design/rtcca_req_if.sv
// ----------------------------------------------------------------------------
// rtcca_req_if: request channel
// valid/ready handshake carrying one bus access, tick or soft reset item
// ----------------------------------------------------------------------------
`default_nettype none

interface rtcca_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] addr;
  logic [7:0] wdata;

  modport source (output valid, req_type, addr, wdata, input ready);
  modport sink   (input valid, req_type, addr, wdata, output ready);
endinterface

`default_nettype wire

>>> design/rtcca_rsp_if.sv
// ----------------------------------------------------------------------------
// rtcca_rsp_if: response channel
// valid/ready handshake carrying the read byte and the interrupt indication
// ----------------------------------------------------------------------------
`default_nettype none

interface rtcca_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq_raise;

  modport source (output valid, rdata, irq_raise, input ready);
  modport sink   (input valid, rdata, irq_raise, output ready);
endinterface

`default_nettype wire

>>> design/rtc_calendar_alarm_registers_top.sv
// ----------------------------------------------------------------------------
// rtc_calendar_alarm_registers_top: register-mapped rtc, calendar and alarm
// bus reads/writes to time, alarm, control, flag registers and user ram;
// tick items advance the clock by one second
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                   meaning
//   req      in         req_type, addr, wdata     read, write, tick, soft reset
//   rsp      out        rdata, irq_raise          one item per request
//
// one item per cycle sustained while rsp is ready; an accepted item passes
// through the input register plus ram read, then the result register
// the whole register update of one item is a single combinational pass
// rst is synchronous: time, alarms, control, flags and ram valid bits return
// to their reset values
// a stalled rsp holds the result; one more req is still taken into the
// input register, after that req.ready drops until rsp drains
//
`default_nettype none

module rtc_calendar_alarm_registers_top #(
  parameter int unsigned RAM_BYTES = rtcca_pkg::RAM_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  rtcca_req_if.sink          req,
  rtcca_rsp_if.source        rsp
);
  import rtcca_pkg::*;

  localparam int unsigned IDX_W = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;

  // input register
  logic              iv;
  req_kind_t         i_kind;
  logic [5:0]        i_addr;
  logic [7:0]        i_wdata;
  logic [7:0]        ram_q;

  // result register
  logic              ov;
  logic [7:0]        o_rdata;
  logic              o_irq;

  // architectural state
  time_t             tm, tm_next;
  alarm_t            al, al_next;
  logic [6:0]        ctrl_a, ctrl_a_next;   // bit 7 can never be set
  logic [7:0]        ctrl_b, ctrl_b_next;
  flags_t            flags, flags_next;
  logic              fb_done, fb_done_next;

  // user ram with per-entry valid bits, an unwritten entry reads zero
  logic [7:0]        mem [RAM_BYTES];
  logic [RAM_BYTES-1:0] ram_valid;

  logic              advance, in_fire;
  logic [5:0]        i_off, n_off;
  logic [IDX_W-1:0]  i_idx, n_idx;
  logic              i_in_ram, ram_we;
  logic [7:0]        rd;
  logic              irq;
  tick_t             tk;

  // handshake: the input register moves on whenever the result register frees
  assign advance   = iv & (~ov | rsp.ready);
  assign req.ready = ~iv | advance;
  assign in_fire   = req.valid & req.ready;

  assign rsp.valid     = ov;
  assign rsp.rdata     = o_rdata;
  assign rsp.irq_raise = o_irq;

  // ram addressing for the item in the input register and the incoming one
  assign i_off    = 6'(i_addr - RAM_BASE);
  assign n_off    = 6'(req.addr - RAM_BASE);
  assign i_idx    = i_off[IDX_W-1:0];
  assign n_idx    = n_off[IDX_W-1:0];
  assign i_in_ram = (i_addr >= RAM_BASE) && ({1'b0, i_off} < 7'(RAM_BYTES));
  assign ram_we   = advance && (i_kind == REQ_WRITE) && i_in_ram;

  rtcca_tick u_tick (
    .cur            (tm),
    .alarm          (al),
    .ctrl_b         (ctrl_b),
    .fall_back_done (fb_done),
    .res            (tk)
  );

  // register update for the item in the input register
  always_comb begin
    tm_next      = tm;
    al_next      = al;
    ctrl_a_next  = ctrl_a;
    ctrl_b_next  = ctrl_b;
    flags_next   = flags;
    fb_done_next = fb_done;
    rd           = '0;
    irq          = 1'b0;
    unique case (i_kind)
      REQ_READ: begin
        unique case (i_addr)
          ADDR_SEC:        rd = tm.sec;
          ADDR_ALARM_SEC:  rd = al.sec;
          ADDR_MIN:        rd = tm.min;
          ADDR_ALARM_MIN:  rd = al.min;
          ADDR_HOUR:       rd = tm.hour;
          ADDR_ALARM_HOUR: rd = al.hour;
          ADDR_WEEKDAY:    rd = tm.weekday;
          ADDR_DAY:        rd = tm.day;
          ADDR_MONTH:      rd = tm.month;
          ADDR_YEAR:       rd = tm.year;
          ADDR_CTRL_A:     rd = {1'b0, ctrl_a};
          ADDR_CTRL_B:     rd = ctrl_b;
          ADDR_FLAGS: begin
            // read clears the flags
            rd         = {flags.irqf, 1'b0, flags.af, flags.uf, 4'b0};
            flags_next = '0;
          end
          ADDR_STATUS:     rd = STATUS_D_VALUE;
          default:         rd = i_in_ram ? ram_q : 8'h00;
        endcase
      end
      REQ_WRITE: begin
        unique case (i_addr)
          ADDR_SEC:        tm_next.sec     = i_wdata;
          ADDR_ALARM_SEC:  al_next.sec     = i_wdata;
          ADDR_MIN:        tm_next.min     = i_wdata;
          ADDR_ALARM_MIN:  al_next.min     = i_wdata;
          ADDR_HOUR:       tm_next.hour    = i_wdata;
          ADDR_ALARM_HOUR: al_next.hour    = i_wdata;
          ADDR_WEEKDAY:    tm_next.weekday = i_wdata;
          ADDR_DAY:        tm_next.day     = i_wdata;
          ADDR_MONTH:      tm_next.month   = i_wdata;
          ADDR_YEAR:       tm_next.year    = i_wdata;
          ADDR_CTRL_A:     ctrl_a_next     = i_wdata[6:0];
          ADDR_CTRL_B:     ctrl_b_next     = i_wdata;
          // flags, status are read only; ram goes through ram_we
          default: ;
        endcase
      end
      REQ_TICK: begin
        // set bit freezes the clock and the flags
        if (!ctrl_b[CTRL_B_SET]) begin
          tm_next       = tk.nxt;
          fb_done_next  = fb_done | tk.fb_set;
          flags_next.uf = 1'b1;
          if (ctrl_b[CTRL_B_UIE]) begin
            flags_next.irqf = 1'b1;
            irq             = 1'b1;
          end
          if (tk.alarm_match) begin
            flags_next.af = 1'b1;
            if (ctrl_b[CTRL_B_AIE]) begin
              flags_next.irqf = 1'b1;
              irq             = 1'b1;
            end
          end
        end
      end
      REQ_SOFT_RESET: begin
        ctrl_b_next = ctrl_b & CTRL_B_SOFT_MASK;
        flags_next  = '0;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      iv        <= 1'b0;
      ov        <= 1'b0;
      tm        <= TIME_RESET;
      al        <= '0;
      ctrl_a    <= '0;
      ctrl_b    <= CTRL_B_RESET;
      flags     <= '0;
      fb_done   <= 1'b0;
      ram_valid <= '0;
    end else begin
      if (in_fire) iv <= 1'b1;
      else if (advance) iv <= 1'b0;

      if (advance) begin
        ov      <= 1'b1;
        tm      <= tm_next;
        al      <= al_next;
        ctrl_a  <= ctrl_a_next;
        ctrl_b  <= ctrl_b_next;
        flags   <= flags_next;
        fb_done <= fb_done_next;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end

      if (ram_we) ram_valid[i_idx] <= 1'b1;
    end
  end

  // payload registers and ram
  always_ff @(posedge clk) begin
    if (in_fire) begin
      i_kind  <= req_kind_t'(req.req_type);
      i_addr  <= req.addr;
      i_wdata <= req.wdata;
      // forward a write to the same entry retiring at this edge
      if (ram_we && (i_idx == n_idx)) ram_q <= i_wdata;
      else if (ram_valid[n_idx]) ram_q <= mem[n_idx];
      else ram_q <= 8'h00;
    end
    if (advance) begin
      o_rdata <= rd;
      o_irq   <= irq;
    end
    if (ram_we) mem[i_idx] <= i_wdata;
  end

`ifndef SYNTH
  // an interrupt in the result always leaves the irq flag set behind it
  a_irq_sets_flag: assert property (@(posedge clk) disable iff (rst)
    ov && o_irq |-> flags.irqf)
    else $error("irq result without irq flag");

  // only a tick can raise the interrupt
  a_irq_only_tick: assert property (@(posedge clk) disable iff (rst)
    advance && (i_kind != REQ_TICK) |=> !o_irq)
    else $error("irq raised by a non-tick item");

  // a tick with the set bit on leaves the clock alone
  a_set_freezes: assert property (@(posedge clk) disable iff (rst)
    advance && (i_kind == REQ_TICK) && ctrl_b[CTRL_B_SET] |=> $stable(tm))
    else $error("time moved while set bit on");

  // a held item in the input register is never dropped
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    iv && !advance |=> iv)
    else $error("pending item lost");
`endif

endmodule

`default_nettype wire

>>> design/rtcca_tick.sv
// ----------------------------------------------------------------------------
// rtcca_tick: one-second advance of the time and calendar
// bcd or binary, 12h or 24h, daylight-saving jumps and alarm compare
// ----------------------------------------------------------------------------
`default_nettype none

module rtcca_tick (
  input  rtcca_pkg::time_t  cur,
  input  rtcca_pkg::alarm_t alarm,
  input  logic [7:0]        ctrl_b,
  input  logic              fall_back_done,
  output rtcca_pkg::tick_t  res
);
  import rtcca_pkg::*;

  typedef struct packed {
    logic       carry;
    logic [7:0] val;
  } step_t;

  // bcd byte to value, nibbles are not range checked
  function automatic logic [7:0] value_of(input logic [7:0] v, input logic bin);
    logic [7:0] hi;
    hi = {4'b0, v[7:4]};
    if (bin) return v;
    return 8'((hi << 3) + (hi << 1) + {4'b0, v[3:0]});
  endfunction

  function automatic logic [7:0] plain_inc(input logic [7:0] v, input logic bin);
    if (!bin && v[3:0] == 4'd9) return 8'({v[7:4], 4'b0} + 8'h10);
    return 8'(v + 8'd1);
  endfunction

  function automatic step_t step_field(input logic [7:0] v, input logic bin,
                                       input logic [7:0] lo,
                                       input logic [7:0] hi_bin,
                                       input logic [7:0] hi_bcd);
    step_t s;
    s.val   = plain_inc(v, bin);
    s.carry = 1'b0;
    if (s.val > (bin ? hi_bin : hi_bcd)) begin
      s.val   = lo;
      s.carry = 1'b1;
    end
    return s;
  endfunction

  function automatic step_t step_hour(input logic [7:0] h, input logic [1:0] mode);
    step_t s;
    s.carry = 1'b0;
    s.val   = 8'(h + 8'd1);
    unique case (mode)
      2'b00: begin  // 12h bcd
        if (h == 8'h12) s.val = 8'h81;
        else if (h == 8'h92) begin
          s.val   = 8'h01;
          s.carry = 1'b1;
        end else s.val = plain_inc(h, 1'b0);
      end
      2'b01: begin  // 24h bcd
        if (h == 8'h23) begin
          s.val   = 8'h00;
          s.carry = 1'b1;
        end else s.val = plain_inc(h, 1'b0);
      end
      2'b10: begin  // 12h binary
        if (h == 8'h0C) s.val = 8'h81;
        else if (h == 8'h8C) begin
          s.val   = 8'h01;
          s.carry = 1'b1;
        end
      end
      default: begin  // 24h binary
        if (h == 8'h17) begin
          s.val   = 8'h00;
          s.carry = 1'b1;
        end
      end
    endcase
    return s;
  endfunction

  function automatic logic [7:0] month_len(input logic [3:0] m);
    unique case (m)
      4'd2:                      return 8'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 8'd30;
      default:                   return 8'd31;
    endcase
  endfunction

  function automatic logic alarm_hit(input logic [7:0] al, input logic [7:0] t);
    return (al[7:6] == 2'b11) || (al == t);
  endfunction

  logic       bin;
  logic [7:0] sec_v, min_v, day_v, mon_v, yr_v;
  logic [7:0] mon_clamp;
  logic       leap_feb;
  logic       at_159, spring, fall;
  step_t      sec_s, min_s, hr_s, wd_s, day_s, mon_s, yr_s;

  assign bin = ctrl_b[CTRL_B_BIN];

  always_comb begin
    sec_v = value_of(cur.sec, bin);
    min_v = value_of(cur.min, bin);
    day_v = value_of(cur.day, bin);
    mon_v = value_of(cur.month, bin);
    yr_v  = value_of(cur.year, bin);

    // month reading clamped to 1..12 for the length lookup
    if (mon_v < 8'd1) mon_clamp = 8'd1;
    else if (mon_v > 8'd12) mon_clamp = 8'd12;
    else mon_clamp = mon_v;
    leap_feb = (mon_clamp == 8'd2) && (yr_v[1:0] == 2'b00);

    sec_s = step_field(cur.sec, bin, 8'd0, 8'd59, 8'h59);
    min_s = step_field(cur.min, bin, 8'd0, 8'd59, 8'h59);
    hr_s  = step_hour(cur.hour, {ctrl_b[CTRL_B_BIN], ctrl_b[CTRL_B_24H]});
    wd_s  = step_field(cur.weekday, bin, 8'd1, 8'd7, 8'h07);
    mon_s = step_field(cur.month, bin, 8'd1, 8'd12, 8'h12);
    yr_s  = step_field(cur.year, bin, 8'd0, 8'd99, 8'h99);

    // day rolls over only on an exact match of the month length
    day_s.carry = leap_feb ? (day_v == 8'd29) : (day_v == month_len(mon_clamp[3:0]));
    day_s.val   = day_s.carry ? 8'd1 : plain_inc(cur.day, bin);

    at_159 = ctrl_b[CTRL_B_DSE] && cur.hour == 8'h01 && min_v == 8'd59 &&
             sec_v == 8'd59 && cur.weekday == 8'h01;
    spring = at_159 && cur.month == 8'h04 && day_v >= 8'd24;
    fall   = at_159 && mon_v == 8'd10 && day_v >= 8'd25 && !fall_back_done;

    res.nxt    = cur;
    res.fb_set = 1'b0;
    priority if (spring) begin
      res.nxt.hour = 8'h03;
      res.nxt.min  = 8'h00;
      res.nxt.sec  = 8'h00;
    end else if (fall) begin
      res.fb_set   = 1'b1;
      res.nxt.hour = 8'h01;
      res.nxt.min  = 8'h00;
      res.nxt.sec  = 8'h00;
    end else begin
      res.nxt.sec = sec_s.val;
      if (sec_s.carry) begin
        res.nxt.min = min_s.val;
        if (min_s.carry) begin
          res.nxt.hour = hr_s.val;
          if (hr_s.carry) begin
            res.nxt.weekday = wd_s.val;
            res.nxt.day     = day_s.val;
            if (day_s.carry) begin
              res.nxt.month = mon_s.val;
              if (mon_s.carry) res.nxt.year = yr_s.val;
            end
          end
        end
      end
    end

    res.alarm_match = alarm_hit(alarm.sec, res.nxt.sec) &&
                      alarm_hit(alarm.min, res.nxt.min) &&
                      alarm_hit(alarm.hour, res.nxt.hour);
  end

endmodule

`default_nettype wire
